FILE: design/kab_pkg.sv
// Shared types, register codes, reset values and saturation helpers of the angle/bias filter.
package kab_pkg;

  typedef struct packed {
    logic signed [31:0] angle_meas;
    logic signed [31:0] gyro_meas;
  } in_t;

  typedef struct packed {
    logic signed [31:0] angle_est;
    logic signed [31:0] rate_est;
  } out_t;

  typedef struct packed {
    logic        start;
    logic [49:0] a;
    logic [47:0] b;
  } mul_req_t;

  typedef struct packed {
    logic        start;
    logic [47:0] num;
    logic [48:0] den;
  } div_req_t;

  localparam logic [2:0] CFG_STEP_TIME   = 3'd0;
  localparam logic [2:0] CFG_ANGLE_NOISE = 3'd1;
  localparam logic [2:0] CFG_BIAS_NOISE  = 3'd2;
  localparam logic [2:0] CFG_MEAS_NOISE  = 3'd3;

  localparam logic [31:0] STEP_TIME_RST   = 32'd21474836;
  localparam logic [46:0] ANGLE_NOISE_RST = 47'd10995116278;
  localparam logic [46:0] BIAS_NOISE_RST  = 47'd109951163;
  localparam logic [46:0] MEAS_NOISE_RST  = 47'd10995116277760;
  localparam logic signed [47:0] COV_ONE  = 48'sd1099511627776;

  function automatic logic signed [31:0] sat32(input logic signed [59:0] v);
    logic signed [31:0] r;
    if (v > 60'sd2147483647) begin
      r = 32'sh7FFF_FFFF;
    end else if (v < -60'sd2147483648) begin
      r = 32'sh8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  function automatic logic signed [47:0] sat48(input logic signed [59:0] v);
    logic signed [47:0] r;
    if (v > 60'sd140737488355327) begin
      r = 48'sh7FFF_FFFF_FFFF;
    end else if (v < -60'sd140737488355328) begin
      r = 48'sh8000_0000_0000;
    end else begin
      r = v[47:0];
    end
    return r;
  endfunction

endpackage

FILE: design/kab_mul.sv
// Bit-serial shift-add multiplier, one multiplier bit per cycle.
module kab_mul (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  kab_pkg::mul_req_t req_i,
  output logic             done_o,
  output logic [97:0]      prod_o
);

  logic [97:0] p_q, p_d;
  logic [49:0] a_q;
  logic [47:0] b_q;
  logic [5:0]  cnt_q;
  logic        busy_q;
  logic [50:0] sum;

  assign sum  = {1'b0, p_q[97:48]} + (b_q[0] ? {1'b0, a_q} : 51'd0);
  assign p_d  = {sum, p_q[47:1]};
  assign prod_o = p_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
      done_o <= 1'b0;
    end else begin
      done_o <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= 6'd48;
      end else if (busy_q) begin
        cnt_q <= cnt_q - 6'd1;
        if (cnt_q == 6'd1) begin
          busy_q <= 1'b0;
          done_o <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      p_q <= '0;
      a_q <= req_i.a;
      b_q <= req_i.b;
    end else if (busy_q) begin
      p_q <= p_d;
      b_q <= {1'b0, b_q[47:1]};
    end
  end

endmodule

FILE: design/kab_div.sv
// Restoring divider for Q7.40 gains, one quotient bit per cycle, saturating.
module kab_div (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  kab_pkg::div_req_t req_i,
  output logic             done_o,
  output logic [46:0]      quot_o
);

  logic [48:0] rem_q, den_q;
  logic [47:0] sh_q, q_q;
  logic [5:0]  cnt_q;
  logic        busy_q, ovf_q;
  logic [49:0] t;
  logic        ge;
  logic [49:0] diff;

  assign t    = {rem_q, sh_q[47]};
  assign ge   = t >= {1'b0, den_q};
  assign diff = t - {1'b0, den_q};
  assign quot_o = ovf_q ? {47{1'b1}} : q_q[46:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
      done_o <= 1'b0;
    end else begin
      done_o <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= 6'd48;
      end else if (busy_q) begin
        cnt_q <= cnt_q - 6'd1;
        if (cnt_q == 6'd1) begin
          busy_q <= 1'b0;
          done_o <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      ovf_q <= {req_i.den, 7'd0} <= {8'd0, req_i.num};
      den_q <= req_i.den;
      rem_q <= {9'd0, req_i.num[47:8]};
      sh_q  <= {req_i.num[7:0], 40'd0};
      q_q   <= '0;
    end else if (busy_q) begin
      rem_q <= ge ? diff[48:0] : t[48:0];
      sh_q  <= {sh_q[46:0], 1'b0};
      q_q   <= {q_q[46:0], ge};
    end
  end

endmodule

FILE: design/kalman_angle_bias_filter.sv
// Top level of the two-state angle and gyro-bias Kalman filter with its step sequencer.
//
//   channel  | valid        | stall        | payload
//   input    | in_valid_i   | in_stall_o   | in_data_i  (angle_meas, gyro_meas)
//   output   | out_valid_o  | out_stall_i  | out_data_o (angle_est, rate_est)
//   config   | cfg_we_i     | none         | cfg_idx_i, cfg_data_i
//
// An item runs from its accept to its result through ten serial multiplies and
// one gain divide, each started and then written back; the gain divide runs two
// dividers in parallel. When the innovation variance is not positive the divide
// is skipped. All multiplies use the one shared bit-serial multiplier.
// Reset restores the registers and the filter state at once.
// The next item is taken while a finished result waits under a stall.
module kalman_angle_bias_filter (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  kab_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output kab_pkg::out_t out_data_o,
  input  logic          cfg_we_i,
  input  logic [2:0]    cfg_idx_i,
  input  logic [46:0]   cfg_data_i
);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_MUL  = 4'b0010,
    ST_DIV  = 4'b0100,
    ST_OUT  = 4'b1000
  } state_e;

  typedef enum logic [3:0] {
    OP_RATE_DT, OP_X_DT, OP_P11_DT, OP_QB_DT, OP_K1_P00,
    OP_K1_P01, OP_K0_P00, OP_K0_P01, OP_K0_ERR, OP_K1_ERR
  } op_e;

  state_e state_q;
  op_e    op_q;
  logic   go_q;

  logic [31:0] dt_q;
  logic [46:0] qa_q, qb_q, r_q;
  logic signed [31:0] angle_q, bias_q, am_q, gm_q;
  logic signed [47:0] c00_q, c01_q, c10_q, c11_q;
  logic signed [32:0] err_q;
  logic [46:0] k0_q, k1_q;
  logic        k0n_q, k1n_q;

  kab_pkg::mul_req_t mreq;
  kab_pkg::div_req_t dreq0, dreq1;
  logic        mdone, ddone0, ddone1;
  logic [97:0] prod;
  logic [46:0] quot0, quot1;

  logic signed [31:0] rate_now;
  logic signed [50:0] opnd;
  logic [49:0] opnd_mag;
  logic        use_k, ksel, sub, neg, s40;
  logic signed [59:0] base, rs, sum, sum_b;
  logic [98:0] rnd_sum;
  logic [57:0] r_mag;
  logic signed [31:0] wb32;
  logic signed [47:0] wb48, wb48_b;
  logic signed [49:0] e_sum;
  logic        e_pos;
  logic        out_load;

  assign rate_now = kab_pkg::sat32(60'(gm_q) - 60'(bias_q));

  always_comb begin
    opnd  = '0;
    use_k = 1'b0;
    ksel  = 1'b0;
    sub   = 1'b0;
    base  = '0;
    case (op_q)
      OP_RATE_DT: begin
        opnd = 51'(rate_now);
        base = 60'(angle_q);
      end
      OP_X_DT: begin
        opnd = 51'($signed({1'b0, qa_q})) - 51'(c01_q) - 51'(c10_q);
        base = 60'(c00_q);
      end
      OP_P11_DT: begin
        opnd = 51'(c11_q);
        base = 60'(c01_q);
        sub  = 1'b1;
      end
      OP_QB_DT: begin
        opnd = 51'($signed({1'b0, qb_q}));
        base = 60'(c11_q);
      end
      OP_K1_P00: begin
        opnd = 51'(c00_q); use_k = 1'b1; ksel = 1'b1; base = 60'(c10_q); sub = 1'b1;
      end
      OP_K1_P01: begin
        opnd = 51'(c01_q); use_k = 1'b1; ksel = 1'b1; base = 60'(c11_q); sub = 1'b1;
      end
      OP_K0_P00: begin
        opnd = 51'(c00_q); use_k = 1'b1; base = 60'(c00_q); sub = 1'b1;
      end
      OP_K0_P01: begin
        opnd = 51'(c01_q); use_k = 1'b1; base = 60'(c01_q); sub = 1'b1;
      end
      OP_K0_ERR: begin
        opnd = 51'(err_q); use_k = 1'b1; base = 60'(angle_q);
      end
      OP_K1_ERR: begin
        opnd = 51'(err_q); use_k = 1'b1; ksel = 1'b1; base = 60'(bias_q);
      end
      default: begin
        opnd = '0;
      end
    endcase
  end

  assign opnd_mag = opnd[50] ? 50'(-opnd) : opnd[49:0];
  assign s40      = use_k;
  assign neg      = opnd[50] ^ (use_k & (ksel ? k1n_q : k0n_q));

  assign mreq.start = (state_q == ST_MUL) && !go_q;
  assign mreq.a     = opnd_mag;
  assign mreq.b     = use_k ? {1'b0, (ksel ? k1_q : k0_q)} : {16'd0, dt_q};

  assign rnd_sum = {1'b0, prod} + (s40 ? (99'd1 << 39) : (99'd1 << 31));
  assign r_mag   = s40 ? rnd_sum[97:40] : rnd_sum[89:32];
  assign rs      = neg ? -$signed({2'b00, r_mag}) : $signed({2'b00, r_mag});
  assign sum     = sub ? base - rs : base + rs;
  assign sum_b   = 60'(c10_q) - rs;
  assign wb32    = kab_pkg::sat32(sum);
  assign wb48    = kab_pkg::sat48(sum);
  assign wb48_b  = kab_pkg::sat48(sum_b);

  assign e_sum = $signed({3'b000, r_q}) + 50'(c00_q);
  assign e_pos = !e_sum[49] && (e_sum != '0);

  assign dreq0.start = (state_q == ST_DIV) && !go_q && e_pos;
  assign dreq0.num   = c00_q[47] ? 48'(-c00_q) : c00_q;
  assign dreq0.den   = e_sum[48:0];
  assign dreq1.start = dreq0.start;
  assign dreq1.num   = c10_q[47] ? 48'(-c10_q) : c10_q;
  assign dreq1.den   = e_sum[48:0];

  kab_mul u_mul (.clk_i, .rst_ni, .req_i(mreq), .done_o(mdone), .prod_o(prod));
  kab_div u_div0 (.clk_i, .rst_ni, .req_i(dreq0), .done_o(ddone0), .quot_o(quot0));
  kab_div u_div1 (.clk_i, .rst_ni, .req_i(dreq1), .done_o(ddone1), .quot_o(quot1));

  assign in_stall_o = (state_q != ST_IDLE);
  assign out_load   = (state_q == ST_OUT) && (!out_valid_o || !out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      op_q        <= OP_RATE_DT;
      go_q        <= 1'b0;
      out_valid_o <= 1'b0;
      dt_q        <= kab_pkg::STEP_TIME_RST;
      qa_q        <= kab_pkg::ANGLE_NOISE_RST;
      qb_q        <= kab_pkg::BIAS_NOISE_RST;
      r_q         <= kab_pkg::MEAS_NOISE_RST;
      angle_q     <= '0;
      bias_q      <= '0;
      c00_q       <= kab_pkg::COV_ONE;
      c01_q       <= '0;
      c10_q       <= '0;
      c11_q       <= kab_pkg::COV_ONE;
      k0_q        <= '0;
      k1_q        <= '0;
      k0n_q       <= 1'b0;
      k1n_q       <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          kab_pkg::CFG_STEP_TIME:   dt_q <= cfg_data_i[31:0];
          kab_pkg::CFG_ANGLE_NOISE: qa_q <= cfg_data_i;
          kab_pkg::CFG_BIAS_NOISE:  qb_q <= cfg_data_i;
          kab_pkg::CFG_MEAS_NOISE:  r_q  <= cfg_data_i;
          default: ;
        endcase
      end
      if (out_load) begin
        out_valid_o <= 1'b1;
      end else if (out_valid_o && !out_stall_i) begin
        out_valid_o <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            state_q <= ST_MUL;
            op_q    <= OP_RATE_DT;
            go_q    <= 1'b0;
          end
        end
        ST_MUL: begin
          if (!go_q) begin
            go_q <= 1'b1;
          end else if (mdone) begin
            go_q <= 1'b0;
            op_q <= op_e'(4'(op_q) + 4'd1);
            case (op_q)
              OP_RATE_DT: angle_q <= wb32;
              OP_X_DT:    c00_q <= wb48;
              OP_P11_DT: begin
                c01_q <= wb48;
                c10_q <= wb48_b;
              end
              OP_QB_DT:   c11_q <= wb48;
              OP_K1_P00:  c10_q <= wb48;
              OP_K1_P01:  c11_q <= wb48;
              OP_K0_P00:  c00_q <= wb48;
              OP_K0_P01:  c01_q <= wb48;
              OP_K0_ERR:  angle_q <= wb32;
              OP_K1_ERR:  bias_q <= wb32;
              default: ;
            endcase
            if (op_q == OP_QB_DT) begin
              state_q <= ST_DIV;
            end else if (op_q == OP_K1_ERR) begin
              state_q <= ST_OUT;
            end
          end
        end
        ST_DIV: begin
          if (!go_q) begin
            if (e_pos) begin
              go_q <= 1'b1;
            end else begin
              k0_q    <= '0;
              k1_q    <= '0;
              k0n_q   <= 1'b0;
              k1n_q   <= 1'b0;
              state_q <= ST_MUL;
            end
          end else if (ddone0 && ddone1) begin
            k0_q    <= quot0;
            k1_q    <= quot1;
            k0n_q   <= c00_q[47];
            k1n_q   <= c10_q[47];
            go_q    <= 1'b0;
            state_q <= ST_MUL;
          end
        end
        ST_OUT: begin
          if (out_load) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && in_valid_i) begin
      am_q <= in_data_i.angle_meas;
      gm_q <= in_data_i.gyro_meas;
    end
    if (state_q == ST_MUL && go_q && mdone && op_q == OP_RATE_DT) begin
      err_q <= 33'(am_q) - 33'(wb32);
    end
    if (out_load) begin
      out_data_o.angle_est <= angle_q;
      out_data_o.rate_est  <= rate_now;
    end
  end

endmodule

FILE: design/kab_chk.sv
// Port-level checker of the angle/bias filter and its bind to the top level.
module kab_chk (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          in_valid_i,
  input logic          in_stall_o,
  input logic          out_valid_o,
  input logic          out_stall_i,
  input kab_pkg::out_t out_data_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result item changed or vanished");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input not stalled while an item is in work");

  a_no_early_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && !out_valid_o |=> !out_valid_o)
    else $error("result item appeared right after its input item");

  a_result_frees_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> !in_stall_o)
    else $error("input still stalled after a result item was produced");

endmodule

bind kalman_angle_bias_filter kab_chk u_kab_chk (.*);
